>>> sv/gwb_pkg.sv
`default_nettype none

package gwb_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int SUM_W         = 24;
  localparam int GAIN_W        = 24;
  localparam int TOT_W         = SUM_W + 2;
  localparam int NUM_LANES     = 3;
  localparam int MAX_SIDE_DEF  = 256;
  localparam int GAIN_FRAC_DEF = 16;
  localparam int SIDE_RESET    = 256;

  localparam int LANE_BLUE  = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_RED   = 2;

  localparam logic [PIX_W-1:0]  PIX_MAX  = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_APPLY   = 2'd2
  } gwb_cmd_t;

  typedef struct packed {
    logic measure;
    logic finish;
  } gwb_lane_ctl_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } gwb_pos_ctl_t;

  typedef struct packed {
    logic in_circle;
    logic last;
  } gwb_pos_t;

endpackage

`default_nettype wire

>>> sv/gwb_in_if.sv
`default_nettype none

interface gwb_in_if import gwb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] red_in;

  modport source (output valid, command, blue_in, green_in, red_in, input ready);
  modport sink (input valid, command, blue_in, green_in, red_in, output ready);
endinterface

`default_nettype wire

>>> sv/gwb_out_if.sv
`default_nettype none

interface gwb_out_if import gwb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] red_out;
  logic             inside_circle;
  logic             last_pixel;

  modport source (output valid, blue_out, green_out, red_out, inside_circle, last_pixel,
                  input ready);
  modport sink (input valid, blue_out, green_out, red_out, inside_circle, last_pixel,
                output ready);
endinterface

`default_nettype wire

>>> sv/gwb_lane.sv
`default_nettype none

module gwb_lane import gwb_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gwb_lane_ctl_t     ctl,
  input  logic [PIX_W-1:0]  sample,
  input  logic [TOT_W-1:0]  total,
  output logic [SUM_W-1:0]  sum,
  output logic [PIX_W-1:0]  scaled,
  output logic              busy
);

  localparam int NUM_W  = TOT_W + GAIN_FRAC_BITS;
  localparam int DIV_W  = SUM_W + 2;
  localparam int REM_W  = DIV_W + 1;
  localparam int CMP_W  = (NUM_W > DIV_W + GAIN_W) ? NUM_W : DIV_W + GAIN_W;
  localparam int CNT_W  = $clog2(GAIN_W + 1);
  localparam int MUL_W  = PIX_W + GAIN_W;
  localparam int PROD_W = MUL_W + 1;
  localparam logic [GAIN_W-1:0] UNITY = (GAIN_FRAC_BITS >= GAIN_W) ? GAIN_MAX :
                                        (GAIN_W'(1) << GAIN_FRAC_BITS);
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DIV   = 3'b100
  } lane_state_t;

  lane_state_t        state;
  logic [GAIN_W-1:0]  gain;
  logic [NUM_W-1:0]   num;
  logic [DIV_W-1:0]   divisor;
  logic               sum_zero;
  logic [REM_W-1:0]   rem;
  logic [GAIN_W-1:0]  low;
  logic [GAIN_W-1:0]  quot;
  logic [CNT_W-1:0]   cnt;

  logic [SUM_W:0]     sum_add;
  logic [REM_W-1:0]   trial;
  logic [REM_W-1:0]   diff;
  logic               fits;
  logic               ovf;
  logic [MUL_W-1:0]   prod;
  logic [PROD_W-1:0]  rounded;
  logic [PROD_W-1:0]  shifted;

  assign sum_add = {1'b0, sum} + (SUM_W + 1)'(sample);
  assign trial   = {rem[DIV_W-1:0], low[GAIN_W-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign diff    = trial - {1'b0, divisor};
  // quotient would not fit in the gain register
  assign ovf     = CMP_W'(num) >= (CMP_W'(divisor) << GAIN_W);

  assign prod    = MUL_W'(sample) * MUL_W'(gain);
  assign rounded = PROD_W'(prod) + HALF;
  assign shifted = rounded >> GAIN_FRAC_BITS;
  assign scaled  = (shifted > PROD_W'(PIX_MAX)) ? PIX_MAX : shifted[PIX_W-1:0];

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      gain  <= UNITY;
      sum   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.finish) begin
            num      <= NUM_W'(total) << GAIN_FRAC_BITS;
            divisor  <= (DIV_W'(sum) << 1) + DIV_W'(sum);
            sum_zero <= (sum == '0);
            sum      <= '0;
            state    <= ST_CHECK;
          end else if (ctl.measure) begin
            sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          end
        end
        ST_CHECK: begin
          if (sum_zero) begin
            gain  <= '0;
            state <= ST_IDLE;
          end else if (ovf) begin
            gain  <= GAIN_MAX;
            state <= ST_IDLE;
          end else begin
            rem   <= REM_W'(num >> GAIN_W);
            low   <= num[GAIN_W-1:0];
            cnt   <= CNT_W'(GAIN_W);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle, restoring
          rem  <= fits ? diff : trial;
          low  <= low << 1;
          quot <= {quot[GAIN_W-2:0], fits};
          cnt  <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            gain  <= {quot[GAIN_W-2:0], fits};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/gwb_circle.sv
`default_nettype none

module gwb_circle import gwb_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] cols_cfg,
  input  logic [CFG_W-1:0] rows_cfg,
  input  gwb_pos_ctl_t     ctl,
  output gwb_pos_t         pos
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int EXT_W  = CFG_W + SIDE_W;
  localparam int SQ_W   = 2 * SIDE_W;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    if (v == '0) return SIDE_W'(1);
    if (EXT_W'(v) > EXT_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
    return SIDE_W'(v);
  endfunction

  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  row;

  logic [SIDE_W-1:0] cols;
  logic [SIDE_W-1:0] rows;
  logic [SIDE_W-1:0] radius;
  logic [SIDE_W-1:0] cy;
  logic [SIDE_W-1:0] col_ext;
  logic [SIDE_W-1:0] row_ext;
  logic [SIDE_W-1:0] adx;
  logic [SIDE_W-1:0] ady;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  logic [SQ_W-1:0]   sq_r;
  logic [SQ_W:0]     dist_sq;
  logic              col_end;
  logic              row_end;

  assign cols    = clamp_side(cols_cfg);
  assign rows    = clamp_side(rows_cfg);
  assign radius  = cols >> 1;
  assign cy      = rows >> 1;
  assign col_ext = SIDE_W'(col);
  assign row_ext = SIDE_W'(row);
  assign adx     = (col_ext >= radius) ? col_ext - radius : radius - col_ext;
  assign ady     = (row_ext >= cy) ? row_ext - cy : cy - row_ext;
  assign sq_x    = adx * adx;
  assign sq_y    = ady * ady;
  assign sq_r    = radius * radius;
  assign dist_sq = (SQ_W + 1)'(sq_x) + (SQ_W + 1)'(sq_y);
  assign col_end = (col_ext + SIDE_W'(1)) >= cols;
  assign row_end = (row_ext + SIDE_W'(1)) >= rows;

  assign pos.in_circle = dist_sq <= (SQ_W + 1)'(sq_r);
  assign pos.last      = col_end & row_end;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      col <= '0;
      row <= '0;
    end else if (ctl.advance) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + POS_W'(1);
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/gray_world_balance_incircle_mask.sv
`default_nettype none

// Gray-world white balance with an inscribed-circle mask. Stream the image once with
// command measure to build the three channel sums, send one finish item to turn them
// into Q8.GAIN_FRAC_BITS gains, then stream it again with command apply; each apply
// beat returns one balanced pixel, zeroed outside the circle of radius cols/2, with
// last_pixel set on the final pixel. Measure and apply beats are taken one per cycle
// while the result register drains. A finish beat starts the three lane dividers,
// which produce one gain bit per cycle: the port stays closed while they run, through
// one range check and then the quotient bits, or the range check alone when every gain
// is zero or saturates. Write image_cols/image_rows only while no item is in flight.
module gray_world_balance_incircle_mask import gwb_pkg::*; #(
  parameter int MAX_SIDE       = MAX_SIDE_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  gwb_in_if.sink               pixels,
  gwb_out_if.source            results,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] image_cols;
  logic [CFG_W-1:0] image_rows;

  logic [PIX_W-1:0] samples    [NUM_LANES];
  logic [SUM_W-1:0] lane_sum   [NUM_LANES];
  logic [PIX_W-1:0] lane_scaled[NUM_LANES];
  logic [NUM_LANES-1:0] lane_busy;
  logic [TOT_W-1:0] total;

  gwb_lane_ctl_t lane_ctl;
  gwb_pos_ctl_t  pos_ctl;
  gwb_pos_t      pos;

  logic busy;
  logic accept;
  logic apply_acc;

  logic             out_valid;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_red;
  logic             out_inside;
  logic             out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= CFG_W'(SIDE_RESET);
      image_rows <= CFG_W'(SIDE_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLS: image_cols <= cfg_data;
        REG_ROWS: image_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy         = |lane_busy;
  assign pixels.ready = !busy && (!out_valid || results.ready);
  assign accept       = pixels.valid && pixels.ready;

  assign lane_ctl.measure = accept && (pixels.command == CMD_MEASURE);
  assign lane_ctl.finish  = accept && (pixels.command == CMD_FINISH);
  assign apply_acc        = accept && (pixels.command == CMD_APPLY);
  assign pos_ctl.advance  = apply_acc;
  assign pos_ctl.clear    = lane_ctl.finish;

  assign samples[LANE_BLUE]  = pixels.blue_in;
  assign samples[LANE_GREEN] = pixels.green_in;
  assign samples[LANE_RED]   = pixels.red_in;

  assign total = TOT_W'(lane_sum[LANE_BLUE]) + TOT_W'(lane_sum[LANE_GREEN])
               + TOT_W'(lane_sum[LANE_RED]);

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    gwb_lane #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .sample (samples[i]),
      .total  (total),
      .sum    (lane_sum[i]),
      .scaled (lane_scaled[i]),
      .busy   (lane_busy[i])
    );
  end

  gwb_circle #(
    .MAX_SIDE(MAX_SIDE)
  ) u_circle (
    .clk      (clk),
    .rst      (rst),
    .cols_cfg (image_cols),
    .rows_cfg (image_rows),
    .ctl      (pos_ctl),
    .pos      (pos)
  );

  // merge the lanes with the mask into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_acc) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (apply_acc) begin
      out_blue   <= pos.in_circle ? lane_scaled[LANE_BLUE] : '0;
      out_green  <= pos.in_circle ? lane_scaled[LANE_GREEN] : '0;
      out_red    <= pos.in_circle ? lane_scaled[LANE_RED] : '0;
      out_inside <= pos.in_circle;
      out_last   <= pos.last;
    end
  end

  assign results.valid         = out_valid;
  assign results.blue_out      = out_blue;
  assign results.green_out     = out_green;
  assign results.red_out       = out_red;
  assign results.inside_circle = out_inside;
  assign results.last_pixel    = out_last;

`ifndef SYNTH
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    lane_ctl.finish |=> busy)
    else $error("finish beat did not start the gain dividers");

  a_busy_closed: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pixels.ready)
    else $error("input open while gains are being computed");

  a_apply_result: assert property (@(posedge clk) disable iff (rst)
    apply_acc |=> results.valid)
    else $error("apply beat produced no result");

  a_mask_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.inside_circle |->
      results.blue_out == '0 && results.green_out == '0 && results.red_out == '0)
    else $error("pixel outside circle not masked");
`endif

endmodule

`default_nettype wire
